@@ sv/vic_pkg.sv @@
// Shared types and constants for the vectored interrupt controller with RTC.
// Holds the bus event codes, control byte bit positions and configuration layout.
// No dependencies.
package vic_pkg;

    // Bus event carried with each request.
    typedef enum logic [1:0] {
        MODE_IO_WRITE  = 2'd0,
        MODE_INT_ACK   = 2'd1,
        MODE_CLK_TICK  = 2'd2,
        MODE_POR_CLEAR = 2'd3
    } vic_mode_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_BOARD_ENABLE   = 3'd0,
        CFG_IO_PORT        = 3'd1,
        CFG_RTC_BASE_SEL   = 3'd2,
        CFG_RTC_DIVIDE_SEL = 3'd3,
        CFG_RTC_JUMPER     = 3'd4,
        CFG_TICKS_CLK_BASE = 3'd5,
        CFG_TICKS_LINE_BASE = 3'd6
    } vic_cfg_idx_t;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Control byte bit positions.
    localparam int unsigned CTL_LEVEL_LIVE_BIT = 3;
    localparam int unsigned CTL_CLR_RTC_BIT    = 4;
    localparam int unsigned CTL_RTC_ON_BIT     = 6;
    localparam int unsigned CTL_VECTOR_ON_BIT  = 7;

    localparam logic [7:0] RST_OPCODE_BASE = 8'hC7;
    localparam logic [7:0] IDLE_READ_DATA  = 8'hFF;
    localparam logic [3:0] LEVEL_NONE      = 4'd8;

    // Base period times the largest divide ratio fits this many bits.
    localparam int unsigned PRODUCT_W = 26;
    localparam int unsigned DIV_W     = 10;

    // Live configuration as seen by the datapath.
    typedef struct packed {
        logic        board_enable;
        logic [7:0]  io_port;
        logic        rtc_base_sel;
        logic [1:0]  rtc_divide_sel;
        logic [3:0]  rtc_jumper;
        logic [15:0] ticks_per_clock_base;
        logic [15:0] ticks_per_line_base;
    } vic_cfg_t;

    // Divide ratio selected by rtc_divide_sel.
    function automatic logic [DIV_W-1:0] divide_ratio(input logic [1:0] sel);
        logic [DIV_W-1:0] r;
        unique case (sel)
            2'd0:    r = 10'd1;
            2'd1:    r = 10'd10;
            2'd2:    r = 10'd100;
            default: r = 10'd1000;
        endcase
        return r;
    endfunction

endpackage

@@ sv/vic_cfg_regs.sv @@
// Configuration register file and derived RTC period for the interrupt controller.
// Depends on vic_pkg for the register layout and divide ratio table.
module vic_cfg_regs #(
    parameter int COUNT_WIDTH = 26
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [vic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vic_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output vic_pkg::vic_cfg_t              cfg,
    output logic                           cfg_hit,
    output logic [COUNT_WIDTH:0]           period
);

    localparam int PER_W = COUNT_WIDTH + 1;
    localparam int CMP_W = (PER_W > vic_pkg::PRODUCT_W) ? PER_W : vic_pkg::PRODUCT_W;

    vic_pkg::vic_cfg_t               cfg_reg;
    vic_pkg::vic_cfg_t               cfg_next;
    logic [PER_W-1:0]                period_val;
    logic [15:0]                     base;
    logic [vic_pkg::PRODUCT_W-1:0]   product;
    logic [CMP_W-1:0]                product_ext;
    logic [CMP_W-1:0]                cap;

    always_comb begin
        cfg_next = cfg_reg;
        cfg_hit  = 1'b0;
        if (cfg_wr_en) begin
            cfg_hit = 1'b1;
            unique case (cfg_index)
                vic_pkg::CFG_BOARD_ENABLE:    cfg_next.board_enable = cfg_wdata[0];
                vic_pkg::CFG_IO_PORT:         cfg_next.io_port = cfg_wdata[7:0];
                vic_pkg::CFG_RTC_BASE_SEL:    cfg_next.rtc_base_sel = cfg_wdata[0];
                vic_pkg::CFG_RTC_DIVIDE_SEL:  cfg_next.rtc_divide_sel = cfg_wdata[1:0];
                vic_pkg::CFG_RTC_JUMPER:      cfg_next.rtc_jumper = cfg_wdata[3:0];
                vic_pkg::CFG_TICKS_CLK_BASE:  cfg_next.ticks_per_clock_base = cfg_wdata;
                vic_pkg::CFG_TICKS_LINE_BASE: cfg_next.ticks_per_line_base = cfg_wdata;
                default:                      cfg_hit = 1'b0;
            endcase
        end
    end

    // Period is base times divide ratio, clamped to the counter range.
    always_comb begin
        base        = cfg_reg.rtc_base_sel ? cfg_reg.ticks_per_clock_base
                                           : cfg_reg.ticks_per_line_base;
        product     = vic_pkg::PRODUCT_W'(base)
                    * vic_pkg::PRODUCT_W'(vic_pkg::divide_ratio(cfg_reg.rtc_divide_sel));
        product_ext = CMP_W'(product);
        cap         = CMP_W'(1) << COUNT_WIDTH;
        period_val  = (product_ext > cap) ? PER_W'(cap) : PER_W'(product_ext);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.board_enable         <= 1'b1;
            cfg_reg.io_port              <= 8'hFE;
            cfg_reg.rtc_base_sel         <= 1'b1;
            cfg_reg.rtc_divide_sel       <= 2'd0;
            cfg_reg.rtc_jumper           <= 4'd8;
            cfg_reg.ticks_per_clock_base <= 16'd200;
            cfg_reg.ticks_per_line_base  <= 16'd33333;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg    = cfg_reg;
    assign period = period_val;

endmodule

@@ sv/vic_prio_enc.sv @@
// Priority encoder for the eight vectored interrupt lines plus the strapped RTC flag.
// Depends on vic_pkg for the no-winner code.
module vic_prio_enc (
    input  logic [7:0] external_lines,
    input  logic       rtc_flag,
    input  logic [3:0] rtc_jumper,
    input  logic [2:0] current_level,
    input  logic       level_live,
    output logic [3:0] winning_level
);

    logic [7:0] lines;
    logic [3:0] lowest;

    always_comb begin
        lines = external_lines;
        if (rtc_flag && !rtc_jumper[3]) begin
            lines[rtc_jumper[2:0]] = 1'b1;
        end
        // Scan from the top so the lowest set line wins.
        lowest = vic_pkg::LEVEL_NONE;
        for (int i = 7; i >= 0; i--) begin
            if (lines[i]) begin
                lowest = 4'(i);
            end
        end
        // A masked winner blocks everything below it as well.
        if (!lowest[3] && level_live && (lowest[2:0] >= current_level)) begin
            winning_level = vic_pkg::LEVEL_NONE;
        end else begin
            winning_level = lowest;
        end
    end

endmodule

@@ sv/vectored_interrupt_controller_rtc_core.sv @@
// Vectored interrupt controller with real-time clock: one request in, one result out.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle sustained; back-pressure on the result side stalls input.
// The RTC period is formed from the live registers, so a request sees every register write
// that has taken effect by the time it is processed.
// Reset (aresetn low, synchronous) loads register defaults and clears all controller state.
module vectored_interrupt_controller_rtc_core #(
    parameter int COUNT_WIDTH = 26
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input requests.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,  // port_addr, data_byte, external_lines
    input  logic [1:0]                     s_tuser,  // mode
    // Results.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,  // claimed, read_data, int_request,
                                                     // winning_level, zero fill
    // Configuration writes.
    input  logic                           cfg_wr_en,
    input  logic [vic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vic_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PER_W = COUNT_WIDTH + 1;

    // Configuration and the derived RTC period.
    vic_pkg::vic_cfg_t      cfg;
    logic                   cfg_hit;
    logic [PER_W-1:0]       period;

    vic_cfg_regs #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .cfg_hit   (cfg_hit),
        .period    (period)
    );

    // Input register stage.
    logic              in_valid_reg;
    logic              in_valid_next;
    vic_pkg::vic_mode_t in_mode_reg;
    logic [7:0]        in_port_reg;
    logic [7:0]        in_data_reg;
    logic [7:0]        in_ext_reg;

    // Result register stage.
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [15:0]       out_data_reg;
    logic [15:0]       out_data_next;

    // Controller state.
    logic [2:0]             current_level_reg, current_level_next;
    logic                   level_live_reg, level_live_next;
    logic                   rtc_flag_reg, rtc_flag_next;
    logic                   rtc_on_reg, rtc_on_next;
    logic                   vectoring_on_reg, vectoring_on_next;
    logic [COUNT_WIDTH-1:0] divider_count_reg, divider_count_next;

    logic              s_accept;
    logic              proc_fire;
    logic              port_match;
    logic              rtc_armed;
    logic [PER_W-1:0]  count_inc;
    logic [3:0]        winning_level;
    logic              winner_ok;
    logic              claimed;
    logic [7:0]        read_data;
    logic              int_request;

    // The processing stage moves an item whenever the result register is free
    // or is being emptied this cycle; the input register refills in the same cycle.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_accept  = s_tvalid && s_tready;

    assign port_match = cfg.board_enable && (in_port_reg == cfg.io_port);
    assign rtc_armed  = rtc_on_reg && !cfg.rtc_jumper[3] && (period != '0);
    assign count_inc  = PER_W'(divider_count_reg) + PER_W'(1);

    // Next controller state for the item held in the input register.
    always_comb begin
        current_level_next = current_level_reg;
        level_live_next    = level_live_reg;
        rtc_flag_next      = rtc_flag_reg;
        rtc_on_next        = rtc_on_reg;
        vectoring_on_next  = vectoring_on_reg;
        divider_count_next = divider_count_reg;
        unique case (in_mode_reg)
            vic_pkg::MODE_IO_WRITE: begin
                if (port_match) begin
                    // The level field is written inverted on the bus.
                    current_level_next = ~in_data_reg[2:0];
                    level_live_next    = in_data_reg[vic_pkg::CTL_LEVEL_LIVE_BIT];
                    if (in_data_reg[vic_pkg::CTL_CLR_RTC_BIT]) begin
                        rtc_flag_next = 1'b0;
                    end
                    rtc_on_next        = in_data_reg[vic_pkg::CTL_RTC_ON_BIT];
                    vectoring_on_next  = in_data_reg[vic_pkg::CTL_VECTOR_ON_BIT];
                    divider_count_next = '0;
                end
            end
            vic_pkg::MODE_INT_ACK: begin
                // An acknowledge only reads the state.
            end
            vic_pkg::MODE_CLK_TICK: begin
                if (rtc_armed) begin
                    if (count_inc >= period) begin
                        rtc_flag_next      = 1'b1;
                        divider_count_next = '0;
                    end else begin
                        divider_count_next = count_inc[COUNT_WIDTH-1:0];
                    end
                end else begin
                    divider_count_next = '0;
                end
            end
            default: begin
                current_level_next = '0;
                level_live_next    = 1'b0;
                rtc_flag_next      = 1'b0;
                rtc_on_next        = 1'b0;
                vectoring_on_next  = 1'b0;
                divider_count_next = '0;
            end
        endcase
    end

    // The winner is taken from the state after the item. An acknowledge leaves
    // the state alone, so the same encoder also serves the acknowledge answer.
    vic_prio_enc u_prio_enc (
        .external_lines (in_ext_reg),
        .rtc_flag       (rtc_flag_next),
        .rtc_jumper     (cfg.rtc_jumper),
        .current_level  (current_level_next),
        .level_live     (level_live_next),
        .winning_level  (winning_level)
    );

    assign winner_ok   = !winning_level[3];
    assign int_request = vectoring_on_next && winner_ok;

    always_comb begin
        claimed   = 1'b0;
        read_data = vic_pkg::IDLE_READ_DATA;
        unique case (in_mode_reg)
            vic_pkg::MODE_IO_WRITE: begin
                claimed = port_match;
            end
            vic_pkg::MODE_INT_ACK: begin
                if (cfg.board_enable && vectoring_on_reg && winner_ok) begin
                    claimed   = 1'b1;
                    read_data = vic_pkg::RST_OPCODE_BASE | {2'b00, winning_level[2:0], 3'b000};
                end
            end
            default: begin
                claimed = 1'b0;
            end
        endcase
        out_data_next = {2'b00, winning_level, int_request, read_data, claimed};
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (proc_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Handshake control and controller state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            current_level_reg <= '0;
            level_live_reg    <= 1'b0;
            rtc_flag_reg      <= 1'b0;
            rtc_on_reg        <= 1'b0;
            vectoring_on_reg  <= 1'b0;
            divider_count_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc_fire) begin
                current_level_reg <= current_level_next;
                level_live_reg    <= level_live_next;
                rtc_flag_reg      <= rtc_flag_next;
                rtc_on_reg        <= rtc_on_next;
                vectoring_on_reg  <= vectoring_on_next;
            end
            // Any register write restarts the RTC divider.
            if (cfg_hit) begin
                divider_count_reg <= '0;
            end else if (proc_fire) begin
                divider_count_reg <= divider_count_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg <= vic_pkg::vic_mode_t'(s_tuser);
            in_port_reg <= s_tdata[7:0];
            in_data_reg <= s_tdata[15:8];
            in_ext_reg  <= s_tdata[23:16];
        end
        if (proc_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ tb/vectored_interrupt_controller_rtc_core_tb.sv @@
// Self-checking testbench for vectored_interrupt_controller_rtc_core.
// Runs a directed table and random bus events through a predictor of the controller.
// Depends on vic_pkg and on the core module only.
module vectored_interrupt_controller_rtc_core_tb;

    localparam int COUNT_W          = 26;
    localparam int QUIET_LIMIT      = 400;   // cycles with nothing moving before giving up
    localparam int DIRECTED_N       = 21;
    localparam int RANDOM_PER_PHASE = 110;
    localparam int NUM_SETTINGS     = 8;

    // One bus event as it travels on the request channel.
    typedef struct {
        vic_pkg::vic_mode_t mode;
        logic [7:0]         port_addr;
        logic [7:0]         data_byte;
        logic [7:0]         external_lines;
    } bus_event_t;

    // One result as it travels on the result channel.
    typedef struct packed {
        logic       claimed;
        logic [7:0] read_data;
        logic       int_request;
        logic [3:0] winning_level;
    } bus_result_t;

    // A row of the directed table. When typed is set, want is the result read straight
    // off the controller's definition; otherwise the predictor supplies it.
    typedef struct {
        vic_pkg::vic_mode_t mode;
        logic [7:0]         port_addr;
        logic [7:0]         data_byte;
        logic [7:0]         external_lines;
        bit                 typed;
        bus_result_t        want;
    } directed_row_t;

    localparam bus_result_t NO_TYPED = '{1'b0, 8'h00, 1'b0, 4'd0};

    // The first rows start from the reset settings (port 0xFE, strap none), so the
    // typed results follow from the control byte and the external lines alone.
    directed_row_t directed_rows [DIRECTED_N] = '{
        // Acknowledge with nothing pending, then with every line pending but vectoring off.
        '{vic_pkg::MODE_INT_ACK,   8'h00, 8'h00, 8'h00, 1'b1, '{1'b0, 8'hFF, 1'b0, 4'd8}},
        '{vic_pkg::MODE_INT_ACK,   8'h00, 8'h00, 8'hFF, 1'b1, '{1'b0, 8'hFF, 1'b0, 4'd0}},
        // A write to another port changes nothing, even with an all-ones byte.
        '{vic_pkg::MODE_IO_WRITE,  8'h00, 8'hFF, 8'h80, 1'b1, '{1'b0, 8'hFF, 1'b0, 4'd7}},
        // Vectoring on, level not live.
        '{vic_pkg::MODE_IO_WRITE,  8'hFE, 8'h80, 8'h00, 1'b1, '{1'b1, 8'hFF, 1'b0, 4'd8}},
        '{vic_pkg::MODE_INT_ACK,   8'h00, 8'h00, 8'h80, 1'b1, '{1'b1, 8'hFF, 1'b1, 4'd7}},
        '{vic_pkg::MODE_INT_ACK,   8'h00, 8'h00, 8'h01, 1'b1, '{1'b1, 8'hC7, 1'b1, 4'd0}},
        // Level live at 7: line 7 is masked, line 6 gets through.
        '{vic_pkg::MODE_IO_WRITE,  8'hFE, 8'h88, 8'h80, 1'b1, '{1'b1, 8'hFF, 1'b0, 4'd8}},
        '{vic_pkg::MODE_INT_ACK,   8'h00, 8'h00, 8'hC0, 1'b1, '{1'b1, 8'hF7, 1'b1, 4'd6}},
        // Level live at 0 masks every line, so the acknowledge goes unanswered.
        '{vic_pkg::MODE_IO_WRITE,  8'hFE, 8'h8F, 8'h01, 1'b1, '{1'b1, 8'hFF, 1'b0, 4'd8}},
        '{vic_pkg::MODE_INT_ACK,   8'h00, 8'h00, 8'hFF, 1'b1, '{1'b0, 8'hFF, 1'b0, 4'd8}},
        // Power-on clear drops vectoring and the level mask.
        '{vic_pkg::MODE_POR_CLEAR, 8'h00, 8'h00, 8'h02, 1'b1, '{1'b0, 8'hFF, 1'b0, 4'd1}},
        '{vic_pkg::MODE_CLK_TICK,  8'h00, 8'h00, 8'h00, 1'b1, '{1'b0, 8'hFF, 1'b0, 4'd8}},
        // The rest is left to the predictor.
        '{vic_pkg::MODE_IO_WRITE,  8'hFE, 8'hFF, 8'h00, 1'b0, NO_TYPED},
        '{vic_pkg::MODE_CLK_TICK,  8'h00, 8'h00, 8'h10, 1'b0, NO_TYPED},
        '{vic_pkg::MODE_IO_WRITE,  8'hFE, 8'h7F, 8'h00, 1'b0, NO_TYPED},
        '{vic_pkg::MODE_INT_ACK,   8'hFF, 8'hFF, 8'h04, 1'b0, NO_TYPED},
        '{vic_pkg::MODE_IO_WRITE,  8'hFF, 8'hC0, 8'h00, 1'b0, NO_TYPED},
        '{vic_pkg::MODE_IO_WRITE,  8'hFE, 8'hC8, 8'h00, 1'b0, NO_TYPED},
        '{vic_pkg::MODE_INT_ACK,   8'h00, 8'h00, 8'h40, 1'b0, NO_TYPED},
        '{vic_pkg::MODE_POR_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b0, NO_TYPED},
        '{vic_pkg::MODE_CLK_TICK,  8'h55, 8'hAA, 8'hAA, 1'b0, NO_TYPED}
    };

    // Register settings walked by the random part, one phase each. Fields run
    // board_enable, io_port, rtc_base_sel, rtc_divide_sel, rtc_jumper, clock base, line base.
    vic_pkg::vic_cfg_t phase_settings [NUM_SETTINGS] = '{
        '{1'b1, 8'h00, 1'b1, 2'd0, 4'd0,  16'd3,     16'hFFFF},  // short clock period
        '{1'b1, 8'hFF, 1'b0, 2'd0, 4'd7,  16'hFFFF,  16'd2},     // short line period
        '{1'b0, 8'h55, 1'b1, 2'd1, 4'd3,  16'd1,     16'd1},     // board disabled
        '{1'b1, 8'hAA, 1'b1, 2'd0, 4'd15, 16'd1,     16'd1},     // strap beyond eight
        '{1'b1, 8'h12, 1'b1, 2'd0, 4'd5,  16'd0,     16'd0},     // zero base
        '{1'b1, 8'hFE, 1'b0, 2'd3, 4'd2,  16'hFFFF,  16'hFFFF},  // longest period
        '{1'b1, 8'h99, 1'b1, 2'd2, 4'd4,  16'd1,     16'h8000},  // divide by 100
        '{1'b1, 8'h3C, 1'b1, 2'd0, 4'd1,  16'd2,     16'h7FFF}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;  // port_addr, data_byte, external_lines
    logic [1:0]  s_tuser   = '0;  // mode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;         // claimed, read_data, int_request, winning_level, zero fill
    logic                           cfg_wr_en = 1'b0;
    logic [vic_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [vic_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    vectored_interrupt_controller_rtc_core #(
        .COUNT_WIDTH (COUNT_W)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor: a shadow of the registers and of the controller state.
    // ------------------------------------------------------------------
    vic_pkg::vic_cfg_t cfg_shadow;
    logic [2:0]        cur_level;
    logic              level_live_q;
    logic              rtc_flag_q;
    logic              rtc_on_q;
    logic              vectoring_q;
    longint unsigned   divider_ticks;

    bus_result_t       owed_results [$];

    int unsigned requests_sent   = 0;
    int unsigned results_seen    = 0;
    int unsigned mismatch_count  = 0;
    int unsigned acks_answered   = 0;
    int unsigned rtc_flag_rises  = 0;
    int unsigned quiet_cycles    = 0;

    // Idling controls, redrawn by the stimulus every 30 requests.
    bit          source_idles    = 1'b0;
    bit          sink_stalls     = 1'b0;

    // RTC period in ticks: base times the selected ratio, clamped to the counter range.
    function automatic longint unsigned rtc_period();
        longint unsigned base;
        longint unsigned ratio;
        longint unsigned ticks;
        base = cfg_shadow.rtc_base_sel ? longint'(cfg_shadow.ticks_per_clock_base)
                                       : longint'(cfg_shadow.ticks_per_line_base);
        case (cfg_shadow.rtc_divide_sel)
            2'd0:    ratio = 1;
            2'd1:    ratio = 10;
            2'd2:    ratio = 100;
            default: ratio = 1000;
        endcase
        ticks = base * ratio;
        if (ticks > (64'd1 << COUNT_W))
            ticks = 64'd1 << COUNT_W;
        return ticks;
    endfunction

    // Lowest pending line, with the RTC flag ORed in on its strapped line, subject to
    // the live level mask. Anything masked or nothing pending gives LEVEL_NONE.
    function automatic logic [3:0] admitted_level(logic [7:0] ext);
        logic [7:0] lines;
        lines = ext;
        if (rtc_flag_q && cfg_shadow.rtc_jumper < 4'd8)
            lines[cfg_shadow.rtc_jumper[2:0]] = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (lines[i]) begin
                if (level_live_q && i >= int'(cur_level))
                    return vic_pkg::LEVEL_NONE;
                return 4'(i);
            end
        end
        return vic_pkg::LEVEL_NONE;
    endfunction

    // Applies one bus event to the shadow state and returns the result it causes.
    function automatic bus_result_t resolve_bus_event(bus_event_t ev);
        bus_result_t     res;
        logic [3:0]      lvl;
        longint unsigned next_ticks;
        res.claimed   = 1'b0;
        res.read_data = vic_pkg::IDLE_READ_DATA;
        case (ev.mode)
            vic_pkg::MODE_IO_WRITE: begin
                if (cfg_shadow.board_enable && ev.port_addr == cfg_shadow.io_port) begin
                    res.claimed  = 1'b1;
                    // The level field is stored inverted.
                    cur_level    = 3'd7 - ev.data_byte[2:0];
                    level_live_q = ev.data_byte[vic_pkg::CTL_LEVEL_LIVE_BIT];
                    if (ev.data_byte[vic_pkg::CTL_CLR_RTC_BIT])
                        rtc_flag_q = 1'b0;
                    rtc_on_q      = ev.data_byte[vic_pkg::CTL_RTC_ON_BIT];
                    vectoring_q   = ev.data_byte[vic_pkg::CTL_VECTOR_ON_BIT];
                    divider_ticks = 0;
                end
            end
            vic_pkg::MODE_INT_ACK: begin
                lvl = admitted_level(ev.external_lines);
                if (cfg_shadow.board_enable && vectoring_q && lvl != vic_pkg::LEVEL_NONE) begin
                    res.claimed   = 1'b1;
                    res.read_data = vic_pkg::RST_OPCODE_BASE | {2'b00, lvl[2:0], 3'b000};
                    acks_answered++;
                end
            end
            vic_pkg::MODE_CLK_TICK: begin
                // Ticks run regardless of board_enable; a disarmed divider sits at zero.
                if (rtc_on_q && cfg_shadow.rtc_jumper < 4'd8 && rtc_period() != 0) begin
                    next_ticks = divider_ticks + 1;
                    if (next_ticks >= rtc_period()) begin
                        if (!rtc_flag_q)
                            rtc_flag_rises++;
                        rtc_flag_q    = 1'b1;
                        divider_ticks = 0;
                    end else begin
                        divider_ticks = next_ticks;
                    end
                end else begin
                    divider_ticks = 0;
                end
            end
            default: begin
                // Power-on clear ignores board_enable and leaves the registers alone.
                cur_level     = '0;
                level_live_q  = 1'b0;
                rtc_flag_q    = 1'b0;
                rtc_on_q      = 1'b0;
                vectoring_q   = 1'b0;
                divider_ticks = 0;
            end
        endcase
        lvl = admitted_level(ev.external_lines);
        // The interrupt pin is not gated by board_enable.
        res.int_request   = vectoring_q && lvl != vic_pkg::LEVEL_NONE;
        res.winning_level = lvl;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and the watchdog.
    // ------------------------------------------------------------------
    task automatic note_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        $display("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, what, got, want);
    endtask

    // Results are sampled at the rising edge, so the values seen are the ones that
    // were stable before it.
    always @(posedge aclk) begin : check_results
        bus_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_results.size() == 0) begin
                note_mismatch("result with nothing owed, tdata", m_tdata, 0);
            end else begin
                want = owed_results.pop_front();
                if (m_tdata[0] !== want.claimed)
                    note_mismatch("claimed", m_tdata[0], want.claimed);
                if (m_tdata[8:1] !== want.read_data)
                    note_mismatch("read_data", m_tdata[8:1], want.read_data);
                if (m_tdata[9] !== want.int_request)
                    note_mismatch("int_request", m_tdata[9], want.int_request);
                if (m_tdata[13:10] !== want.winning_level)
                    note_mismatch("winning_level", m_tdata[13:10], want.winning_level);
            end
            results_seen++;
        end
    end

    // Ends the run when neither side has moved for a long stretch.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles, %0d results still owed",
                     quiet_cycles, owed_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All inputs change at the falling edge.
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 2);
        if (roll < 95)
            return $urandom_range(3, 8);
        return $urandom_range(16, 40);
    endfunction

    // Result side: random back-pressure while sink_stalls is set.
    always @(negedge aclk) begin : drive_ready
        int stall_left;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!sink_stalls || $urandom_range(0, 99) < 75) begin
            m_tready <= 1'b1;
        end else begin
            stall_left = pick_gap() - 1;
            m_tready <= 1'b0;
        end
    end

    // Presents one request, waits for it to be taken, and records what it should cause.
    // Entered and left at a falling edge; s_tvalid gets exactly one update per step.
    task automatic issue_request(bus_event_t ev, bit typed, bus_result_t typed_result);
        int          gap;
        bus_result_t predicted;
        gap = (source_idles && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ev.external_lines, ev.data_byte, ev.port_addr};
        s_tuser  <= ev.mode;
        do @(posedge aclk); while (!s_tready);
        predicted = resolve_bus_event(ev);
        owed_results.insert(owed_results.size(), typed ? typed_result : predicted);
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic write_register(vic_pkg::vic_cfg_idx_t idx,
                                  logic [vic_pkg::CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
    endtask

    // Registers only change while the controller is idle: the request side is parked,
    // every owed result has come back, and the pipeline has had time to empty.
    task automatic load_settings(vic_pkg::vic_cfg_t next);
        s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
        write_register(vic_pkg::CFG_BOARD_ENABLE,    {15'd0, next.board_enable});
        write_register(vic_pkg::CFG_IO_PORT,         {8'd0, next.io_port});
        write_register(vic_pkg::CFG_RTC_BASE_SEL,    {15'd0, next.rtc_base_sel});
        write_register(vic_pkg::CFG_RTC_DIVIDE_SEL,  {14'd0, next.rtc_divide_sel});
        write_register(vic_pkg::CFG_RTC_JUMPER,      {12'd0, next.rtc_jumper});
        write_register(vic_pkg::CFG_TICKS_CLK_BASE,  next.ticks_per_clock_base);
        write_register(vic_pkg::CFG_TICKS_LINE_BASE, next.ticks_per_line_base);
        cfg_wr_en <= 1'b0;
        // The write enable drops and stays low before requests resume.
        @(negedge aclk);
        cfg_shadow    = next;
        divider_ticks = 0;
    endtask

    // Random bus event. Most writes hit the live control port with vectoring and the RTC
    // switched on, so the priority logic and the divider get exercised; the rest is noise.
    function automatic bus_event_t random_bus_event(bit tick_heavy);
        bus_event_t  ev;
        int unsigned roll;
        ev.port_addr      = 8'($urandom);
        ev.data_byte      = 8'($urandom);
        ev.external_lines = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (tick_heavy)
            ev.mode = roll < 5 ? vic_pkg::MODE_IO_WRITE : roll < 15 ? vic_pkg::MODE_INT_ACK :
                      roll < 98 ? vic_pkg::MODE_CLK_TICK : vic_pkg::MODE_POR_CLEAR;
        else
            ev.mode = roll < 12 ? vic_pkg::MODE_IO_WRITE : roll < 45 ? vic_pkg::MODE_INT_ACK :
                      roll < 96 ? vic_pkg::MODE_CLK_TICK : vic_pkg::MODE_POR_CLEAR;
        if (ev.mode == vic_pkg::MODE_IO_WRITE) begin
            if ($urandom_range(0, 99) < 85)
                ev.port_addr = cfg_shadow.io_port;
            if ($urandom_range(0, 99) < 80)
                ev.data_byte[vic_pkg::CTL_VECTOR_ON_BIT] = 1'b1;
            if ($urandom_range(0, 99) < 80)
                ev.data_byte[vic_pkg::CTL_RTC_ON_BIT] = 1'b1;
        end
        // Sparse line patterns make the strapped RTC line and the level mask matter.
        roll = $urandom_range(0, 99);
        if (roll < 40)
            ev.external_lines = 8'h00;
        else if (roll < 75)
            ev.external_lines = 8'h01 << $urandom_range(0, 7);
        return ev;
    endfunction

    task automatic run_random_phase();
        bit tick_heavy;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Every 30 requests, reshuffle idling and the mix. Some stretches run flat out.
            if (n % 30 == 0) begin
                source_idles = $urandom_range(0, 3) != 0;
                sink_stalls  = $urandom_range(0, 3) != 0;
                tick_heavy   = $urandom_range(0, 2) == 0;
            end
            issue_request(random_bus_event(tick_heavy), 1'b0, NO_TYPED);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : main_sequence
        bus_event_t ev;
        // Shadow of the reset settings and the cleared controller state.
        cfg_shadow    = '{1'b1, 8'hFE, 1'b1, 2'd0, 4'd8, 16'd200, 16'd33333};
        cur_level     = '0;
        level_live_q  = 1'b0;
        rtc_flag_q    = 1'b0;
        rtc_on_q      = 1'b0;
        vectoring_q   = 1'b0;
        divider_ticks = 0;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table, run against the reset settings.
        sink_stalls = 1'b1;
        for (int i = 0; i < DIRECTED_N; i++) begin
            ev.mode           = directed_rows[i].mode;
            ev.port_addr      = directed_rows[i].port_addr;
            ev.data_byte      = directed_rows[i].data_byte;
            ev.external_lines = directed_rows[i].external_lines;
            issue_request(ev, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random traffic under the reset settings, then under each prepared setting.
        run_random_phase();
        for (int p = 0; p < NUM_SETTINGS; p++) begin
            load_settings(phase_settings[p]);
            run_random_phase();
        end

        s_tvalid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        // Keep the clock running after the last owed result so that any stray extra result would still be caught.
        repeat (8) @(posedge aclk);

        $display("Ran %0d requests under %0d register settings and checked %0d results.",
                 requests_sent, NUM_SETTINGS + 1, results_seen);
        $display("Acknowledges answered: %0d, RTC flag rises: %0d.",
                 acks_answered, rtc_flag_rises);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
